[hw/rtl/height_perturbed_normal_pack_macros.svh]
// ---------------------------------------------------------------------------
// height_perturbed_normal_pack_macros
// Assertion macros shared by the normal packer RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef HEIGHT_PERTURBED_NORMAL_PACK_MACROS_SVH
`define HEIGHT_PERTURBED_NORMAL_PACK_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HPNP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hpnp check failed");
// next-cycle implication
`define HPNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hpnp check failed");
`else
`define HPNP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HPNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/hpnp_pkg.sv]
// ---------------------------------------------------------------------------
// hpnp_pkg
// Widths, register codes, word types and the byte-to-unit table.
// ---------------------------------------------------------------------------
`default_nettype none
package hpnp_pkg;

	localparam int FRAC_BITS = 12;
	localparam int UW = FRAC_BITS + 2;   // signed unit value
	localparam int SLW = FRAC_BITS + 2;  // slope magnitude
	localparam int NW = FRAC_BITS + 4;   // signed component
	localparam int AW = FRAC_BITS + 3;   // component magnitude
	localparam int RW = FRAC_BITS + 4;   // root width, one cell per bit
	localparam int SW = 2 * RW;          // sum of squares
	localparam int QW = FRAC_BITS + 1;   // quotient bits, one cell per bit
	localparam int PW = 18;              // height diff times strength
	localparam int XW = PW + FRAC_BITS + 1;
	localparam int YW = XW - 8;
	localparam int DIV_SH = YW + 8;
	localparam int CW = YW + 1;
	localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + 64'd254) / 64'd255;
	localparam longint unsigned TINY_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd10000000000;
	localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 10;

	// register indexes
	typedef enum logic [CFG_AW-1:0] {
		REG_NORMAL   = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_ROUGH    = 3'd2,
		REG_STRENGTH = 3'd3,
		REG_DEF_RGH  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic       normal_present;
		logic       height_present;
		logic       roughness_present;
		logic [9:0] slope_strength;
		logic [7:0] default_roughness;
	} cfg_t;

	// input word, last declared field (normal_x_in) in the low byte
	typedef struct packed {
		logic [7:0] rough_in;
		logic [7:0] height_up;
		logic [7:0] height_down;
		logic [7:0] height_right;
		logic [7:0] height_left;
		logic [7:0] normal_z_in;
		logic [7:0] normal_y_in;
		logic [7:0] normal_x_in;
	} tex_in_t;

	// per-texel data that rides along the cell chains; lane 0 x, 1 y, 2 z
	typedef struct packed {
		logic [2:0]         neg;
		logic [2:0][AW-1:0] mag;
		logic               degen;
		logic [7:0]         rough;
	} side_t;

	typedef struct packed {
		logic [RW+1:0] rem;
		logic [RW-1:0] root;
		logic [SW-1:0] rad;
		side_t         side;
	} sq_t;

	typedef struct packed {
		logic [2:0][RW:0] rem;
		logic [2:0][QW-1:0] low;
		logic [2:0][QW-1:0] q;
		logic [RW:0]        d;
		side_t              side;
	} dv_t;

	typedef logic signed [UW-1:0] unit_tbl_t [256];

	// round((2b-255) * 2^F / 255), half away from zero
	function automatic unit_tbl_t build_unit_tbl();
		unit_tbl_t t;
		longint m;
		longint a;
		longint q;
		for (int i = 0; i < 256; i++) begin
			m = 2 * i - 255;
			a = (m < 0) ? -m : m;
			q = ((a << FRAC_BITS) + 127) / 255;
			t[i] = UW'((m < 0) ? -q : q);
		end
		return t;
	endfunction

	localparam unit_tbl_t UNIT_TBL = build_unit_tbl();

endpackage
`default_nettype wire

[hw/rtl/hpnp_front.sv]
// ---------------------------------------------------------------------------
// hpnp_front
// Unit values, height slope, components, squares and their sum (5 stages).
// ---------------------------------------------------------------------------
`default_nettype none
module hpnp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire hpnp_pkg::tex_in_t tin,
	input  wire hpnp_pkg::cfg_t   cfg,
	output logic                  out_valid,
	output hpnp_pkg::sq_t         out_sq
);

	localparam int F = hpnp_pkg::FRAC_BITS;
	localparam int UW = hpnp_pkg::UW;
	localparam int NW = hpnp_pkg::NW;
	localparam int AW = hpnp_pkg::AW;
	localparam int SW = hpnp_pkg::SW;
	localparam int PW = hpnp_pkg::PW;
	localparam int XW = hpnp_pkg::XW;
	localparam int YW = hpnp_pkg::YW;
	localparam int CW = hpnp_pkg::CW;
	localparam int SLW = hpnp_pkg::SLW;
	localparam logic [CW-1:0] RECIP = CW'(hpnp_pkg::RECIP);

	logic [4:0] v_q;

	// stage 1: table lookup and gradient products
	logic signed [8:0] dx, dy;
	logic [7:0] adx, ady;
	logic signed [UW-1:0] ux_s1, uy_s1, uz_s1;
	logic [PW-1:0] px_s1, py_s1;
	logic sgx_s1, sgy_s1;
	logic [7:0] rough_s1;

	assign dx = $signed({1'b0, tin.height_right}) - $signed({1'b0, tin.height_left});
	assign dy = $signed({1'b0, tin.height_up}) - $signed({1'b0, tin.height_down});
	assign adx = dx[8] ? 8'(-dx) : dx[7:0];
	assign ady = dy[8] ? 8'(-dy) : dy[7:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (cfg.normal_present) begin
				ux_s1 <= hpnp_pkg::UNIT_TBL[tin.normal_x_in];
				uy_s1 <= hpnp_pkg::UNIT_TBL[tin.normal_y_in];
				uz_s1 <= hpnp_pkg::UNIT_TBL[tin.normal_z_in];
			end else begin
				ux_s1 <= '0;
				uy_s1 <= '0;
				uz_s1 <= hpnp_pkg::ONE_U;
			end
			px_s1 <= cfg.height_present ? PW'(adx) * PW'(cfg.slope_strength) : '0;
			py_s1 <= cfg.height_present ? PW'(ady) * PW'(cfg.slope_strength) : '0;
			sgx_s1 <= dx[8];
			sgy_s1 <= dy[8];
			rough_s1 <= cfg.roughness_present ? tin.rough_in : cfg.default_roughness;
		end
	end

	// stage 2: divide by 65280 as a shift and a reciprocal multiply
	logic [XW-1:0] xx, xy;
	logic [YW+CW-1:0] mx, my;
	logic [SLW-1:0] slx_s2, sly_s2;
	logic signed [UW-1:0] ux_s2, uy_s2, uz_s2;
	logic sgx_s2, sgy_s2;
	logic [7:0] rough_s2;

	assign xx = {1'b0, px_s1, F'(0)} + XW'(32640);
	assign xy = {1'b0, py_s1, F'(0)} + XW'(32640);
	assign mx = YW'(xx >> 8) * RECIP;
	assign my = YW'(xy >> 8) * RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			slx_s2 <= mx[hpnp_pkg::DIV_SH +: SLW];
			sly_s2 <= my[hpnp_pkg::DIV_SH +: SLW];
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			uz_s2 <= uz_s1;
			sgx_s2 <= sgx_s1;
			sgy_s2 <= sgy_s1;
			rough_s2 <= rough_s1;
		end
	end

	// stage 3: subtract the signed slope
	logic signed [NW-1:0] sx, sy;
	logic signed [NW-1:0] nx_s3, ny_s3, nz_s3;
	logic [7:0] rough_s3;

	assign sx = sgx_s2 ? -$signed(NW'(slx_s2)) : $signed(NW'(slx_s2));
	assign sy = sgy_s2 ? -$signed(NW'(sly_s2)) : $signed(NW'(sly_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3 <= NW'(ux_s2) - sx;
			ny_s3 <= NW'(uy_s2) - sy;
			nz_s3 <= NW'(uz_s2);
			rough_s3 <= rough_s2;
		end
	end

	// stage 4: magnitudes and squares
	logic [2:0][AW-1:0] mag;
	logic [2:0] neg;
	logic [2:0][AW-1:0] mag_s4;
	logic [2:0][2*AW-1:0] sq_s4;
	logic [2:0] neg_s4;
	logic [7:0] rough_s4;

	assign neg = {nz_s3[NW-1], ny_s3[NW-1], nx_s3[NW-1]};
	assign mag[0] = nx_s3[NW-1] ? AW'(-nx_s3) : AW'(nx_s3);
	assign mag[1] = ny_s3[NW-1] ? AW'(-ny_s3) : AW'(ny_s3);
	assign mag[2] = nz_s3[NW-1] ? AW'(-nz_s3) : AW'(nz_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= mag[i] * mag[i];
			end
			mag_s4 <= mag;
			neg_s4 <= neg;
			rough_s4 <= rough_s3;
		end
	end

	// stage 5: sum of squares and the tiny-length test
	logic [SW-1:0] ssum;

	assign ssum = SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			out_sq.rem <= '0;
			out_sq.root <= '0;
			out_sq.rad <= ssum;
			out_sq.side.neg <= neg_s4;
			out_sq.side.mag <= mag_s4;
			out_sq.side.degen <= (ssum <= SW'(hpnp_pkg::TINY_SQ));
			out_sq.side.rough <= rough_s4;
		end
	end

	// valid shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	assign out_valid = v_q[4];

endmodule
`default_nettype wire

[hw/rtl/hpnp_root_cell.sv]
// ---------------------------------------------------------------------------
// hpnp_root_cell
// One root bit per cell: brings down two radicand bits and tries 4r+1.
// ---------------------------------------------------------------------------
`default_nettype none
module hpnp_root_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire hpnp_pkg::sq_t in_sq,
	output logic               out_valid,
	output hpnp_pkg::sq_t      out_sq
);

	localparam int RW = hpnp_pkg::RW;
	localparam int SW = hpnp_pkg::SW;

	logic [RW+1:0] rem_sh, trial;
	logic ge;

	// trial subtract
	assign rem_sh = {in_sq.rem[RW-1:0], in_sq.rad[SW-1 -: 2]};
	assign trial = {in_sq.root, 2'b01};
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			out_sq.rem <= ge ? (rem_sh - trial) : rem_sh;
			out_sq.root <= {in_sq.root[RW-2:0], ge};
			out_sq.rad <= {in_sq.rad[SW-3:0], 2'b00};
			out_sq.side <= in_sq.side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/hpnp_div_cell.sv]
// ---------------------------------------------------------------------------
// hpnp_div_cell
// One quotient bit per cell for the three components against 2L.
// ---------------------------------------------------------------------------
`default_nettype none
module hpnp_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire hpnp_pkg::dv_t in_dv,
	output logic               out_valid,
	output hpnp_pkg::dv_t      out_dv
);

	localparam int RW = hpnp_pkg::RW;
	localparam int QW = hpnp_pkg::QW;

	logic [2:0][RW+1:0] rem_sh;
	logic [2:0] ge;

	// restoring step per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {in_dv.rem[i], in_dv.low[i][QW-1]};
			ge[i] = rem_sh[i] >= {1'b0, in_dv.d};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				out_dv.rem[i] <= ge[i] ? (RW+1)'(rem_sh[i] - {1'b0, in_dv.d})
				                       : (RW+1)'(rem_sh[i]);
				out_dv.low[i] <= {in_dv.low[i][QW-2:0], 1'b0};
				out_dv.q[i] <= {in_dv.q[i][QW-2:0], ge[i]};
			end
			out_dv.d <= in_dv.d;
			out_dv.side <= in_dv.side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/height_perturbed_normal_pack.sv]
// ---------------------------------------------------------------------------
// height_perturbed_normal_pack
// Height-perturbed normal and roughness packer, one texel per clock while the skid word is empty.
// ---------------------------------------------------------------------------
// channel   direction  data
// s_axis    in         64-bit texel word (normals, 4 heights, roughness)
// m_axis    out        32-bit packed word (x, y, z, roughness)
// cfg       in         register write, index 0..4
//
// One texel per clock sustained while the skid word is empty; the pipeline is
// 5 front stages, FRAC_BITS+4 root cells, one seed stage and FRAC_BITS+1
// divide cells, plus the output register. Reset clears valid flags and
// loads the register defaults. A full skid word stops the whole pipeline;
// otherwise the block takes a new word while a finished word waits on m_axis.
// ---------------------------------------------------------------------------
`default_nettype none
`include "height_perturbed_normal_pack_macros.svh"
module height_perturbed_normal_pack (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// normal_x_in, normal_y_in, normal_z_in, height_left, height_right,
	// height_down, height_up, rough_in
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// packed_x, packed_y, packed_z, rough_out
	output logic [31:0]      m_axis_tdata,
	input  wire logic        cfg_wen,
	input  wire logic [hpnp_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [hpnp_pkg::CFG_DW-1:0] cfg_wdata
);

	localparam int F = hpnp_pkg::FRAC_BITS;
	localparam int RW = hpnp_pkg::RW;
	localparam int QW = hpnp_pkg::QW;

	hpnp_pkg::cfg_t cfg_q;
	logic en;
	logic skid_v_q;

	assign en = !skid_v_q;
	assign s_axis_tready = en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_present <= 1'b1;
			cfg_q.height_present <= 1'b1;
			cfg_q.roughness_present <= 1'b1;
			cfg_q.slope_strength <= 10'd461;
			cfg_q.default_roughness <= 8'd220;
		end else if (cfg_wen) begin
			case (cfg_addr)
				hpnp_pkg::REG_NORMAL: cfg_q.normal_present <= cfg_wdata[0];
				hpnp_pkg::REG_HEIGHT: cfg_q.height_present <= cfg_wdata[0];
				hpnp_pkg::REG_ROUGH: cfg_q.roughness_present <= cfg_wdata[0];
				hpnp_pkg::REG_STRENGTH: cfg_q.slope_strength <= cfg_wdata[9:0];
				hpnp_pkg::REG_DEF_RGH: cfg_q.default_roughness <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// front stages
	hpnp_pkg::tex_in_t tin;
	hpnp_pkg::sq_t sq_c [RW+1];
	logic sq_v [RW+1];

	assign tin = s_axis_tdata;

	hpnp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_axis_tvalid),
		.tin(tin),
		.cfg(cfg_q),
		.out_valid(sq_v[0]),
		.out_sq(sq_c[0])
	);

	// square root chain
	for (genvar j = 0; j < RW; j++) begin : g_root
		hpnp_root_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(sq_v[j]),
			.in_sq(sq_c[j]),
			.out_valid(sq_v[j+1]),
			.out_sq(sq_c[j+1])
		);
	end

	// seed stage: divisor 2L and the first partial remainders
	hpnp_pkg::dv_t dv_c [QW+1];
	logic dv_v [QW+1];
	logic [RW-1:0] len;

	assign len = (sq_c[RW].root == '0) ? RW'(1) : sq_c[RW].root;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_c[0].rem[i] <= (RW+1)'(sq_c[RW].side.mag[i]) + (RW+1)'(len >> (F+1));
				dv_c[0].low[i] <= len[QW-1:0];
				dv_c[0].q[i] <= '0;
			end
			dv_c[0].d <= {len, 1'b0};
			dv_c[0].side <= sq_c[RW].side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[RW];
		end
	end

	// divide chain
	for (genvar j = 0; j < QW; j++) begin : g_div
		hpnp_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(dv_v[j]),
			.in_dv(dv_c[j]),
			.out_valid(dv_v[j+1]),
			.out_dv(dv_c[j+1])
		);
	end

	// clamp, sign and byte packing
	logic [2:0][QW-1:0] qc;
	logic [2:0][F+1:0] uval;
	logic [2:0][F+9:0] scaled;
	logic [31:0] word;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (dv_c[QW].q[i] > (QW'(1) << F)) ? (QW'(1) << F) : dv_c[QW].q[i];
			uval[i] = dv_c[QW].side.neg[i] ? ((F+2)'(1) << F) - (F+2)'(qc[i])
			                               : ((F+2)'(1) << F) + (F+2)'(qc[i]);
			scaled[i] = ((F+10)'(uval[i]) << 8) - (F+10)'(uval[i]) + ((F+10)'(1) << F);
		end
		if (dv_c[QW].side.degen) begin
			word[23:0] = {8'd255, 8'd128, 8'd128};
		end else begin
			word[7:0] = scaled[0][F+1 +: 8];
			word[15:8] = scaled[1][F+1 +: 8];
			word[23:16] = scaled[2][F+1 +: 8];
		end
		word[31:24] = dv_c[QW].side.rough;
	end

	// output register and skid word
	logic push;
	logic [31:0] skid_q;

	assign push = en && dv_v[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				m_axis_tvalid <= push;
			end
		end else if (!m_axis_tvalid) begin
			m_axis_tvalid <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (skid_v_q) begin
				m_axis_tdata <= skid_q;
			end else if (push) begin
				m_axis_tdata <= word;
			end
		end else if (!m_axis_tvalid) begin
			if (push) begin
				m_axis_tdata <= word;
			end
		end else if (push) begin
			skid_q <= word;
		end
	end

	`HPNP_ASSERT_NOW(a_skid_has_out, clk, arst_n, skid_v_q, m_axis_tvalid)
	`HPNP_ASSERT_NEXT(a_stall_fills_skid, clk, arst_n, m_axis_tvalid && !m_axis_tready && push, skid_v_q)
	`HPNP_ASSERT_NOW(a_skid_drain, clk, arst_n, $fell(skid_v_q), $past(m_axis_tready))

endmodule
`default_nettype wire
